FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// implication or plain property, sampled on clk, off while in reset
`define SXU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never be true
`define SXU_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SXU_ASSERT(lbl, prop, msg)
`define SXU_NEVER(lbl, expr, msg)

`endif

`endif

FILE: hdl/sxu_pkg.sv
// ----------------------------------------------------------------------------
// sxu_pkg
// shared constants, types and header table of the sysex unpack decoder
// ----------------------------------------------------------------------------
package sxu_pkg;

    localparam int BYTE_W         = 7;
    localparam int POS_W          = 4;
    localparam int GROUP_SIZE     = 8;
    localparam int SLOT_W         = $clog2(GROUP_SIZE);
    localparam int BODY_N         = GROUP_SIZE - 1;
    localparam int HDR_LEN        = 5;
    localparam int DATA_START_DEF = 9;

    // command from the message tracker to the group unpacker
    typedef struct packed {
        logic              clear;
        logic              store;
        logic [SLOT_W-1:0] slot;
        logic              flush;
    } sxu_grp_cmd_t;

    // fixed 5-byte header that opens every accepted message
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 7'h00;
            3'd1:    b = 7'h20;
            3'd2:    b = 7'h3C;
            3'd3:    b = 7'h03;
            3'd4:    b = 7'h00;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/sysex_7bit_unpack_rle_decoder_core.sv
// ----------------------------------------------------------------------------
// sysex_7bit_unpack_rle_decoder_core
// sysex 7-to-8-bit group unpacker with run-length expansion
// ----------------------------------------------------------------------------
// Input beats on s_axis carry one sysex data byte; tuser flags the first byte
// after the start of exclusive. Bytes 0..4 must match the fixed header, byte 5
// is the message type, and when it equals the configured dump type, bytes from
// DATA_START_POS on are packed in groups of eight and unpacked.
// Output beats on m_axis carry (value, count) runs; tlast marks the last run
// of a group. Each run is registered in the cycle after its byte is rebuilt.
// Throughput: the beat that closes a group hands it to the rebuild unit,
// which walks the seven data bytes one per cycle while m_axis is not
// stalled; s_axis_tready stays low until the walk ends. Once it ends, a
// run waiting in the output register does not block the next input beat.
// Reset clears position, type, decode state, pending repeat and the dump type
// register. cfg_wr_en writes cfg_wr_data to the dump type register; write it
// only while the block is idle.
// ----------------------------------------------------------------------------
module sysex_7bit_unpack_rle_decoder_core #(
    parameter int DATA_START_POS = sxu_pkg::DATA_START_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [6:0] data_byte, [7] zero
    input  logic                        s_axis_tuser,   // [0] msg_start
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,   // [6:0] run_value, [13:7] run_count
    output logic                        m_axis_tlast,
    input  logic                        cfg_wr_en,
    input  logic [sxu_pkg::BYTE_W-1:0]  cfg_wr_data
);
    import sxu_pkg::*;

    logic [BYTE_W-1:0] dump_type_reg;
    logic              accept;
    logic              busy;
    logic [BYTE_W-1:0] run_value;
    logic [BYTE_W-1:0] run_count;
    sxu_grp_cmd_t      cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dump_type_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            dump_type_reg <= cfg_wr_data;
        end
    end

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sxu_msg_ctrl #(
        .DATA_START_POS (DATA_START_POS)
    ) u_msg_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .msg_start      (s_axis_tuser),
        .data_byte      (s_axis_tdata[BYTE_W-1:0]),
        .dump_type_code (dump_type_reg),
        .cmd            (cmd)
    );

    sxu_unpack_seq u_unpack_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .data_byte      (s_axis_tdata[BYTE_W-1:0]),
        .busy           (busy),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .run_value      (run_value),
        .run_count      (run_count),
        .last_of_group  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, run_count, run_value};

endmodule

FILE: hdl/sxu_msg_ctrl.sv
// ----------------------------------------------------------------------------
// sxu_msg_ctrl
// tracks byte position, header match, message type and group fill level
// ----------------------------------------------------------------------------
module sxu_msg_ctrl #(
    parameter int DATA_START_POS = sxu_pkg::DATA_START_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        msg_start,
    input  logic [sxu_pkg::BYTE_W-1:0]  data_byte,
    input  logic [sxu_pkg::BYTE_W-1:0]  dump_type_code,
    output sxu_pkg::sxu_grp_cmd_t       cmd
);
    import sxu_pkg::*;

    localparam logic [POS_W-1:0] START_POS = POS_W'(DATA_START_POS);
    localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HDR_LEN);

    logic [POS_W-1:0]  pos_reg, pos_next, pos_eff;
    logic [BYTE_W-1:0] type_reg, type_next, type_eff;
    logic              disc_reg, disc_next, disc_eff;
    logic              unp_reg, unp_next, unp_eff, unp_now;
    logic [SLOT_W-1:0] fill_reg, fill_next, fill_eff, fill_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            type_reg <= '0;
            disc_reg <= 1'b0;
            unp_reg  <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            type_reg <= type_next;
            disc_reg <= disc_next;
            unp_reg  <= unp_next;
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        // a flagged start wipes message state before the beat is handled
        pos_eff  = msg_start ? '0   : pos_reg;
        type_eff = msg_start ? '0   : type_reg;
        disc_eff = msg_start ? 1'b0 : disc_reg;
        unp_eff  = msg_start ? 1'b0 : unp_reg;
        fill_eff = msg_start ? '0   : fill_reg;

        pos_next  = pos_reg;
        type_next = type_reg;
        disc_next = disc_reg;
        unp_next  = unp_reg;
        fill_next = fill_reg;
        unp_now   = 1'b0;
        fill_cur  = fill_eff;
        cmd       = '0;

        if (accept)
        begin
            pos_next  = pos_eff;
            type_next = type_eff;
            disc_next = disc_eff;
            unp_next  = unp_eff;
            fill_next = fill_eff;
            cmd.clear = msg_start;
            if (!disc_eff)
            begin
                if ((pos_eff < HDR_POS) && (data_byte != hdr_byte(pos_eff[2:0])))
                begin
                    disc_next = 1'b1;
                end
                else
                begin
                    unp_now = unp_eff;
                    if (pos_eff == HDR_POS)
                    begin
                        type_next = data_byte;
                    end
                    else if ((pos_eff == START_POS) && !unp_eff
                             && (type_eff == dump_type_code))
                    begin
                        unp_now   = 1'b1;
                        unp_next  = 1'b1;
                        fill_cur  = '0;
                    end
                    if (unp_now)
                    begin
                        cmd.store = 1'b1;
                        cmd.slot  = fill_cur;
                        if (fill_cur == SLOT_W'(GROUP_SIZE - 1))
                        begin
                            cmd.flush = 1'b1;
                            fill_next = '0;
                        end
                        else
                        begin
                            fill_next = fill_cur + 1'b1;
                        end
                    end
                    if (pos_eff < START_POS)
                    begin
                        pos_next = pos_eff + 1'b1;
                    end
                end
            end
        end
    end

endmodule

FILE: hdl/sxu_unpack_seq.sv
// ----------------------------------------------------------------------------
// sxu_unpack_seq
// group store and sequencer; one byte per cycle rebuilt into runs if unstalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sxu_unpack_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sxu_pkg::sxu_grp_cmd_t       cmd,
    input  logic [sxu_pkg::BYTE_W-1:0]  data_byte,
    output logic                        busy,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sxu_pkg::BYTE_W-1:0]  run_value,
    output logic [sxu_pkg::BYTE_W-1:0]  run_count,
    output logic                        last_of_group
);
    import sxu_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(BODY_N - 1);

    logic [BYTE_W-1:0] top_reg;
    logic [BYTE_W-1:0] body_reg [BODY_N];
    logic [BYTE_W-1:0] lit_reg;
    logic [BYTE_W-1:0] pend_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              busy_reg;
    logic              ovld_reg;
    logic [BYTE_W-1:0] val_reg;
    logic [BYTE_W-1:0] cnt_reg;
    logic              last_reg;

    logic              advance;
    logic              hi_bit;
    logic [BYTE_W-1:0] cur_byte;
    logic [BYTE_W-1:0] lit_after;
    logic [BYTE_W-1:0] lit_init;
    logic [SLOT_W-1:0] top_sel;
    logic [SLOT_W-1:0] body_sel;

    assign advance   = busy_reg && (!ovld_reg || out_ready);
    assign top_sel   = LAST_IDX - idx_reg;
    assign hi_bit    = top_reg[top_sel];
    assign cur_byte  = body_reg[idx_reg];
    assign lit_after = lit_reg >> idx_reg;
    assign body_sel  = cmd.slot - 1'b1;

    // bit k set when body byte k is a literal
    always_comb
    begin
        for (int k = 0; k < BODY_N; k++)
        begin
            lit_init[k] = !top_reg[BODY_N-1-k];
        end
    end

    // group bytes, no reset needed: each is written before it is read
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            if (cmd.slot == '0)
            begin
                top_reg <= data_byte;
            end
            else
            begin
                body_reg[body_sel] <= data_byte;
            end
        end
        if (cmd.flush)
        begin
            lit_reg <= lit_init;
        end
        if (advance && !hi_bit)
        begin
            val_reg  <= cur_byte;
            cnt_reg  <= (pend_reg != '0) ? pend_reg : BYTE_W'(1);
            // last literal of the group when no literal follows
            last_reg <= (lit_after[BYTE_W-1:1] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            pend_reg <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                pend_reg <= '0;
            end
            else if (advance)
            begin
                pend_reg <= hi_bit ? cur_byte : '0;
            end
            if (advance && !hi_bit)
            begin
                ovld_reg <= 1'b1;
            end
            else if (ovld_reg && out_ready)
            begin
                ovld_reg <= 1'b0;
            end
            if (cmd.flush)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                if (idx_reg == LAST_IDX)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    assign busy          = busy_reg;
    assign out_valid     = ovld_reg;
    assign run_value     = val_reg;
    assign run_count     = cnt_reg;
    assign last_of_group = last_reg;

    `SXU_NEVER(a_store_while_busy, busy_reg && cmd.store, "group write during unpack")
    `SXU_NEVER(a_zero_count, ovld_reg && (cnt_reg == '0), "run emitted with zero count")
    `SXU_ASSERT(a_flush_starts, cmd.flush |=> busy_reg && (idx_reg == '0), "flush did not start")
    `SXU_ASSERT(a_walk_ends, (advance && (idx_reg == LAST_IDX)) |=> !busy_reg, "walk overran")

endmodule
